### src/tet_pkg.sv
`default_nettype none

package tet_pkg;

   // Event types and codes in the evdev numbering
   localparam logic [15:0] EV_SYN = 16'h0000;
   localparam logic [15:0] EV_KEY = 16'h0001;
   localparam logic [15:0] EV_REL = 16'h0002;
   localparam logic [15:0] EV_ABS = 16'h0003;

   localparam logic [15:0] SYN_FRAME = 16'h0000;

   localparam logic [15:0] BTN_MOUSE      = 16'h0110;
   localparam logic [15:0] BTN_CONTACT    = 16'h014a;
   localparam logic [15:0] BTN_FINGER     = 16'h0145;
   localparam logic [15:0] BTN_STYLUS     = 16'h0140;
   localparam logic [15:0] KEY_CODE_LIMIT = 16'h0100;

   localparam logic [15:0] REL_X      = 16'h0000;
   localparam logic [15:0] REL_Y      = 16'h0001;
   localparam logic [15:0] REL_SCROLL = 16'h0008;

   localparam logic [15:0] ABS_X            = 16'h0000;
   localparam logic [15:0] ABS_Y            = 16'h0001;
   localparam logic [15:0] ABS_CONTACT_SLOT = 16'h002f;
   localparam logic [15:0] ABS_CONTACT_X    = 16'h0035;
   localparam logic [15:0] ABS_CONTACT_Y    = 16'h0036;
   localparam logic [15:0] ABS_CONTACT_ID   = 16'h0039;

   // Reset values of the configuration and of the pointer state
   localparam logic [15:0] MAX_X_RESET = 16'd1080;
   localparam logic [15:0] MAX_Y_RESET = 16'd2400;
   localparam logic [31:0] CUR_X_RESET = 32'd540;
   localparam logic [31:0] CUR_Y_RESET = 32'd1200;

   // Configuration register indexes (byte address bit 2)
   localparam logic REG_MAX_X = 1'b0;
   localparam logic REG_MAX_Y = 1'b1;

   // Operations handed from the front to the back
   typedef enum logic [3:0] {
      OP_NONE,
      OP_KEY,
      OP_BUTTON,
      OP_REL_X,
      OP_REL_Y,
      OP_WHEEL,
      OP_ABS_X,
      OP_ABS_Y,
      OP_SLOT,
      OP_TRACK,
      OP_SYNC
   } op_type;

   typedef enum logic [2:0] {
      KIND_KEY         = 3'd0,
      KIND_DOWN        = 3'd1,
      KIND_UP          = 3'd2,
      KIND_MOVE        = 3'd3,
      KIND_SCROLL_UP   = 3'd4,
      KIND_SCROLL_DOWN = 3'd5
   } kind_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  code;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  key_code;
      logic [31:0] key_value;
      logic [31:0] slot;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
   } result_type;

endpackage

`default_nettype wire

### src/tet_front.sv
`default_nettype none

// Classifies each incoming event into an operation; events that can have
// no effect are dropped here and never reach the queue.
module tet_front (
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       ev_type,
   input  wire logic [15:0]       ev_code,
   input  wire logic [31:0]       ev_value,
   input  wire logic              queue_full,
   output logic                   push,
   output tet_pkg::entry_type     push_entry
);

   tet_pkg::op_type op;

   always_comb begin
      op = tet_pkg::OP_NONE;
      case (ev_type)
         tet_pkg::EV_KEY: begin
            if (ev_code < tet_pkg::KEY_CODE_LIMIT) begin
               op = tet_pkg::OP_KEY;
            end else if (ev_code == tet_pkg::BTN_MOUSE || ev_code == tet_pkg::BTN_CONTACT ||
                         ev_code == tet_pkg::BTN_FINGER ||
                         ev_code == tet_pkg::BTN_STYLUS) begin
               op = tet_pkg::OP_BUTTON;
            end
         end
         tet_pkg::EV_REL: begin
            if (ev_code == tet_pkg::REL_X) begin
               op = tet_pkg::OP_REL_X;
            end else if (ev_code == tet_pkg::REL_Y) begin
               op = tet_pkg::OP_REL_Y;
            end else if (ev_code == tet_pkg::REL_SCROLL && ev_value != 32'd0) begin
               op = tet_pkg::OP_WHEEL;
            end
         end
         tet_pkg::EV_ABS: begin
            if (ev_code == tet_pkg::ABS_X || ev_code == tet_pkg::ABS_CONTACT_X) begin
               op = tet_pkg::OP_ABS_X;
            end else if (ev_code == tet_pkg::ABS_Y ||
                         ev_code == tet_pkg::ABS_CONTACT_Y) begin
               op = tet_pkg::OP_ABS_Y;
            end else if (ev_code == tet_pkg::ABS_CONTACT_SLOT) begin
               op = tet_pkg::OP_SLOT;
            end else if (ev_code == tet_pkg::ABS_CONTACT_ID) begin
               op = tet_pkg::OP_TRACK;
            end
         end
         tet_pkg::EV_SYN: begin
            if (ev_code == tet_pkg::SYN_FRAME) begin
               op = tet_pkg::OP_SYNC;
            end
         end
         default: op = tet_pkg::OP_NONE;
      endcase
   end

   assign req_tready       = !queue_full;
   assign push             = req_tvalid && !queue_full && (op != tet_pkg::OP_NONE);
   assign push_entry.op    = op;
   assign push_entry.code  = ev_code[7:0];
   assign push_entry.value = ev_value;

endmodule

`default_nettype wire

### src/tet_queue.sv
`default_nettype none

// Small first-in first-out queue of decoded operations, held in flip-flops.
module tet_queue #(
   parameter int Depth = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tet_pkg::entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output tet_pkg::entry_type      head
);

   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   tet_pkg::entry_type store_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CountW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### src/tet_back.sv
`default_nettype none

// Carries out queued operations against the pointer state and holds the
// result in an output register until the sink takes it.
module tet_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [15:0]        max_x,
   input  wire logic [15:0]        max_y,
   input  wire logic               q_not_empty,
   input  wire tet_pkg::entry_type q_head,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output tet_pkg::result_type     rsp_result
);

   logic [31:0]         cur_x_ff, cur_x_in;
   logic [31:0]         cur_y_ff, cur_y_in;
   logic [31:0]         cur_slot_ff, cur_slot_in;
   logic                is_down_ff, is_down_in;
   logic                pos_seen_ff, pos_seen_in;
   logic                out_valid_ff, out_valid_in;
   tet_pkg::result_type out_ff, out_in;

   logic                has_result;
   tet_pkg::result_type result;
   logic                rel_y;
   logic [31:0]         rel_base;
   logic [15:0]         rel_max;
   logic signed [32:0]  rel_sum;
   logic [31:0]         rel_clamped;
   logic [31:0]         wheel_mag;

   // One shared add-and-clamp for both relative axes
   assign rel_y    = (q_head.op == tet_pkg::OP_REL_Y);
   assign rel_base = rel_y ? cur_y_ff : cur_x_ff;
   assign rel_max  = rel_y ? max_y : max_x;
   assign rel_sum  = $signed({rel_base[31], rel_base}) +
                     $signed({q_head.value[31], q_head.value});

   always_comb begin
      if (rel_sum < 0) begin
         rel_clamped = '0;
      end else if (rel_sum > $signed({17'd0, rel_max})) begin
         rel_clamped = {16'd0, rel_max};
      end else begin
         rel_clamped = rel_sum[31:0];
      end
   end

   // The most negative delta has no positive twin and saturates.
   assign wheel_mag = (q_head.value == 32'h8000_0000) ? 32'h7fff_ffff
                                                      : (32'd0 - q_head.value);

   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      cur_slot_in = cur_slot_ff;
      is_down_in  = is_down_ff;
      pos_seen_in = pos_seen_ff;
      has_result  = 1'b0;
      result.kind      = tet_pkg::KIND_MOVE;
      result.key_code  = '0;
      result.key_value = '0;
      result.slot      = cur_slot_ff;
      result.pos_x     = cur_x_ff;
      result.pos_y     = cur_y_ff;
      case (q_head.op)
         tet_pkg::OP_KEY: begin
            has_result       = 1'b1;
            result.kind      = tet_pkg::KIND_KEY;
            result.key_code  = q_head.code;
            result.key_value = q_head.value;
            result.slot      = '0;
            result.pos_x     = '0;
            result.pos_y     = '0;
         end
         tet_pkg::OP_BUTTON: begin
            has_result  = 1'b1;
            is_down_in  = (q_head.value != 32'd0);
            result.kind = (q_head.value != 32'd0) ? tet_pkg::KIND_DOWN : tet_pkg::KIND_UP;
         end
         tet_pkg::OP_REL_X: begin
            cur_x_in    = rel_clamped;
            pos_seen_in = 1'b1;
         end
         tet_pkg::OP_REL_Y: begin
            cur_y_in    = rel_clamped;
            pos_seen_in = 1'b1;
         end
         tet_pkg::OP_WHEEL: begin
            has_result   = 1'b1;
            result.slot  = '0;
            result.pos_x = '0;
            if (q_head.value[31]) begin
               result.kind  = tet_pkg::KIND_SCROLL_DOWN;
               result.pos_y = wheel_mag;
            end else begin
               result.kind  = tet_pkg::KIND_SCROLL_UP;
               result.pos_y = q_head.value;
            end
         end
         tet_pkg::OP_ABS_X: begin
            cur_x_in    = q_head.value;
            pos_seen_in = 1'b1;
         end
         tet_pkg::OP_ABS_Y: begin
            cur_y_in    = q_head.value;
            pos_seen_in = 1'b1;
         end
         tet_pkg::OP_SLOT: begin
            cur_slot_in = q_head.value;
         end
         tet_pkg::OP_TRACK: begin
            if (q_head.value == 32'hffff_ffff) begin
               has_result  = 1'b1;
               is_down_in  = 1'b0;
               result.kind = tet_pkg::KIND_UP;
            end else begin
               is_down_in = 1'b1;
            end
         end
         tet_pkg::OP_SYNC: begin
            has_result  = pos_seen_ff && is_down_ff;
            pos_seen_in = 1'b0;
         end
         default: has_result = 1'b0;
      endcase
   end

   // An operation without a result never waits for the output register.
   assign pop = q_not_empty && (!out_valid_ff || rsp_tready || !has_result);

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (pop && has_result) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= tet_pkg::CUR_X_RESET;
         cur_y_ff     <= tet_pkg::CUR_Y_RESET;
         cur_slot_ff  <= '0;
         is_down_ff   <= 1'b0;
         pos_seen_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_x_ff    <= cur_x_in;
            cur_y_ff    <= cur_y_in;
            cur_slot_ff <= cur_slot_in;
            is_down_ff  <= is_down_in;
            pos_seen_ff <= pos_seen_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

`default_nettype wire

### src/touch_event_translator.sv
`default_nettype none

// Channel   Direction  Transfer when            Contents
// req_      in         req_tvalid & req_tready  tuser ev_type, tdata code and value
// rsp_      out        rsp_tvalid & rsp_tready  tuser out_kind, tdata result fields
// csr_      in         psel & penable & pwrite  max_x at 0x0, max_y at 0x4
//
// One event transfer is accepted per cycle while the operation queue has room.
// Each event is classified in the cycle it arrives and written to the queue;
// the back end executes one operation per cycle unless a held result stalls
// it, and registers each result in the output register that drives
// rsp_tvalid. The back end's state update and the single add-and-clamp of
// relative motion set that one-per-cycle figure.
// Reset (synchronous, active high) empties the queue and the output register
// and restores the pointer state and the clamp registers to their defaults.
// A stalled sink only holds the back end when an operation has a result to
// deliver; the queue then fills with up to QueueDepth operations before
// req_tready falls.
module touch_event_translator #(
   parameter int QueueDepth = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tuser,    // [15:0] ev_type
   input  wire logic [47:0]  req_tdata,    // [15:0] ev_code, [47:16] ev_value

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [2:0]        rsp_tuser,    // [2:0] out_kind
   output logic [135:0]      rsp_tdata,    // [7:0] key_code, [39:8] key_value,
                                           // [71:40] slot_out,
                                           // [103:72] pos_x_out, [135:104] pos_y_out

   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [15:0]         max_x_ff;
   logic [15:0]         max_y_ff;
   logic                csr_write;

   logic                push;
   tet_pkg::entry_type  push_entry;
   logic                queue_full;
   logic                pop;
   logic                q_not_empty;
   tet_pkg::entry_type  q_head;
   tet_pkg::result_type result;

   // Configuration port. The register is selected by address bit 2; the
   // low address bits are not decoded. Reads are combinational and
   // zero-extended to the bus width.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= tet_pkg::MAX_X_RESET;
         max_y_ff <= tet_pkg::MAX_Y_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == tet_pkg::REG_MAX_X) begin
            max_x_ff <= csr_pwdata[15:0];
         end else begin
            max_y_ff <= csr_pwdata[15:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == tet_pkg::REG_MAX_X) ? {16'd0, max_x_ff}
                                                            : {16'd0, max_y_ff};

   // Front end: decode into an operation and drop events that do nothing.
   tet_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ev_type    (req_tuser),
      .ev_code    (req_tdata[15:0]),
      .ev_value   (req_tdata[47:16]),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue between the two halves, so that each can stall on its own.
   tet_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // Back end: pointer state, clamping and the registered result.
   tet_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_x       (max_x_ff),
      .max_y       (max_y_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_result  (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tdata = {result.pos_y, result.pos_x, result.slot,
                       result.key_value, result.key_code};

endmodule

`default_nettype wire
